[rtl/core/lob_pkg.sv]
// Shared types, field widths and command/status codes for the limit order book.
// Used by every module under rtl/core but lob_ram; depends on nothing else.
`timescale 1ns / 1ps

package lob_pkg;

  // Defaults for the table sizes.
  localparam int MAX_ORDERS_DEF = 1024;
  localparam int MAX_LEVELS_DEF = 64;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int ID_W     = 64;
  localparam int PRICE_W  = 32;
  localparam int SHARES_W = 32;
  localparam int SYM_W    = 64;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int LSH_W    = 40;
  localparam int LORD_W   = 11;

  // Message commands.
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REDUCE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ADD  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_RED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_REPL = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd7;

  // Operations broadcast to a row of level cells.
  localparam logic [1:0] LOP_NOP = 2'd0;
  localparam logic [1:0] LOP_ADD = 2'd1;
  localparam logic [1:0] LOP_SUB = 2'd2;
  localparam logic [1:0] LOP_CLR = 2'd3;

  typedef struct packed {
    logic [1:0]          code;
    logic [PRICE_W-1:0]  price;
    logic [SHARES_W-1:0] amount;
    logic                dec;
  } lvl_op_t;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [LSH_W-1:0]   shares;
    logic [LORD_W-1:0]  orders;
  } lvl_entry_t;

  typedef struct packed {
    logic               add_ok;
    logic [PRICE_W-1:0] best_price;
    lvl_entry_t         rd;
  } lvl_stat_t;

  typedef struct packed {
    logic [ID_W-1:0]     key;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [SHARES_W-1:0] rem;
  } ord_t;

endpackage

[rtl/core/lob_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps

module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lob_level_cell.sv]
// One price level cell of a sorted level row; shifts toward or away from neighbors.
// Depends on lob_pkg.
`timescale 1ns / 1ps

module lob_level_cell #(
  parameter bit IS_ASK = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lob_pkg::lvl_op_t    op_i,
  input  lob_pkg::lvl_entry_t left_i,
  input  logic                left_h_i,
  input  lob_pkg::lvl_entry_t right_i,
  input  logic                found_any_i,
  input  logic                rm_any_i,
  output lob_pkg::lvl_entry_t entry_o,
  output logic                h_o,
  output logic                eq_o,
  output logic                ovf_o,
  output logic                rm_o
);

  localparam int SW1 = lob_pkg::LSH_W + 1;

  logic                        valid_q, valid_d;
  logic [lob_pkg::PRICE_W-1:0] price_q, price_d;
  logic [lob_pkg::LSH_W-1:0]   shares_q, shares_d;
  logic [lob_pkg::LORD_W-1:0]  orders_q, orders_d;
  logic                        beyond;
  logic [SW1-1:0]              sum;

  // Local compares against the broadcast price.
  always_comb begin
    beyond = IS_ASK ? (price_q >= op_i.price) : (price_q <= op_i.price);
    h_o    = !valid_q || beyond;
    eq_o   = valid_q && (price_q == op_i.price);
    sum    = {1'b0, shares_q} + SW1'(op_i.amount);
    ovf_o  = eq_o && (sum[lob_pkg::LSH_W] || (orders_q == '1));
    rm_o   = eq_o && op_i.dec && (orders_q == lob_pkg::LORD_W'(1));
  end

  // Next level contents: keep, update in place, or take a neighbor's.
  always_comb begin
    valid_d  = valid_q;
    price_d  = price_q;
    shares_d = shares_q;
    orders_d = orders_q;
    case (op_i.code)
      lob_pkg::LOP_CLR: begin
        valid_d = 1'b0;
      end
      lob_pkg::LOP_ADD: begin
        if (found_any_i) begin
          if (eq_o) begin
            shares_d = sum[lob_pkg::LSH_W-1:0];
            orders_d = orders_q + lob_pkg::LORD_W'(1);
          end
        end else if (left_h_i) begin
          valid_d  = left_i.valid;
          price_d  = left_i.price;
          shares_d = left_i.shares;
          orders_d = left_i.orders;
        end else if (h_o) begin
          valid_d  = 1'b1;
          price_d  = op_i.price;
          shares_d = lob_pkg::LSH_W'(op_i.amount);
          orders_d = lob_pkg::LORD_W'(1);
        end
      end
      lob_pkg::LOP_SUB: begin
        if (rm_any_i && h_o) begin
          valid_d  = right_i.valid;
          price_d  = right_i.price;
          shares_d = right_i.shares;
          orders_d = right_i.orders;
        end else if (eq_o) begin
          shares_d = shares_q - lob_pkg::LSH_W'(op_i.amount);
          orders_d = orders_q - lob_pkg::LORD_W'(op_i.dec);
        end
      end
      default: begin
      end
    endcase
  end

  // Valid flag is control state; the level data needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    shares_q <= shares_d;
    orders_q <= orders_d;
  end

  assign entry_o = '{valid: valid_q, price: price_q, shares: shares_q, orders: orders_q};

endmodule

[rtl/core/lob_level_side.sv]
// Row of level cells holding one side of the book, best price at cell zero.
// Depends on lob_pkg and lob_level_cell.
`timescale 1ns / 1ps

module lob_level_side #(
  parameter bit IS_ASK     = 1'b0,
  parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lob_pkg::lvl_op_t            op_i,
  input  logic [lob_pkg::RANK_W-1:0]  rank_i,
  output lob_pkg::lvl_stat_t          stat_o
);

  localparam int RW = lob_pkg::RANK_W;

  lob_pkg::lvl_entry_t   entry [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] h, eq, ovf, rm;
  logic                  found_any, rm_any;

  assign found_any = |eq;
  assign rm_any    = |rm;

  // The row of cells; each sees its two neighbors.
  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    lob_pkg::lvl_entry_t left, right;
    logic                left_h;
    if (i == 0) begin : g_first
      assign left   = '0;
      assign left_h = 1'b0;
    end else begin : g_mid
      assign left   = entry[i-1];
      assign left_h = h[i-1];
    end
    if (i == MAX_LEVELS - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entry[i+1];
    end
    lob_level_cell #(.IS_ASK(IS_ASK)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .left_i      (left),
      .left_h_i    (left_h),
      .right_i     (right),
      .found_any_i (found_any),
      .rm_any_i    (rm_any),
      .entry_o     (entry[i]),
      .h_o         (h[i]),
      .eq_o        (eq[i]),
      .ovf_o       (ovf[i]),
      .rm_o        (rm[i])
    );
  end

  // Add check, best price and the level read at the requested rank.
  always_comb begin
    stat_o.add_ok     = found_any ? !(|ovf) : !entry[MAX_LEVELS-1].valid;
    stat_o.best_price = entry[0].valid ? entry[0].price : '0;
    stat_o.rd         = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if ((i < (1 << RW)) && (rank_i == RW'(i)) && entry[i].valid) begin
        stat_o.rd = entry[i];
      end
    end
  end

endmodule

[rtl/core/limit_order_book_unit.sv]
// Price-level limit order book for one symbol: order store in RAM, two sorted level rows.
// Depends on lob_pkg, lob_ram and lob_level_side.
`timescale 1ns / 1ps

// Each message gives exactly one result. Resting orders sit packed at the
// front of a RAM, and every add, reduce, delete or replace first scans the
// live entries for the order id (and the new id of a replace) in one pass,
// one RAM read per cycle. An execute step follows the scan. A delete or a
// full reduce then moves the last order into the freed slot, a replace also
// adds the new order after that move, and a replace whose new order does not
// fit then puts the original order back. Read level and clear skip the scan.
// No new message is taken until the result of the last one is loaded into
// the output register. The bid and ask levels live in two rows of cells that
// insert, update or close a level. A new message is taken while the previous
// result still waits at the output; a stalled result holds the following
// message in its final step.
module limit_order_book_unit #(
  parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF,
  parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lob_pkg::CMD_W-1:0]     cmd_i,
  input  logic [lob_pkg::ID_W-1:0]      order_id_i,
  input  logic [lob_pkg::ID_W-1:0]      new_order_id_i,
  input  logic                          side_i,
  input  logic [lob_pkg::PRICE_W-1:0]   price_i,
  input  logic [lob_pkg::SHARES_W-1:0]  shares_i,
  input  logic [lob_pkg::SYM_W-1:0]     symbol_code_i,
  input  logic [lob_pkg::RANK_W-1:0]    level_rank_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lob_pkg::STATUS_W-1:0]  status_o,
  output logic                          level_valid_o,
  output logic [lob_pkg::PRICE_W-1:0]   level_price_o,
  output logic [lob_pkg::LSH_W-1:0]     level_shares_o,
  output logic [lob_pkg::LORD_W-1:0]    level_orders_o,
  output logic [lob_pkg::PRICE_W-1:0]   best_bid_price_o,
  output logic [lob_pkg::PRICE_W-1:0]   best_ask_price_o
);

  localparam int AW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int OW = $bits(lob_pkg::ord_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_REPL = 3'd5;
  localparam logic [2:0] S_UNDO = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state_q, state_d;

  // Latched message.
  logic [lob_pkg::CMD_W-1:0]    cmd_q;
  logic [lob_pkg::ID_W-1:0]     id_q, nid_q;
  logic                         side_q;
  logic [lob_pkg::PRICE_W-1:0]  price_q;
  logic [lob_pkg::SHARES_W-1:0] shares_q;
  logic [lob_pkg::SYM_W-1:0]    sym_q;
  logic [lob_pkg::RANK_W-1:0]   rank_q;

  // Book-wide state.
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        lock_q, lock_d;
  logic [lob_pkg::SYM_W-1:0]   symv_q, symv_d;

  // Scan state.
  logic [CW-1:0]               iss_q, iss_d;
  logic                        pend_q, pend_d;
  logic [AW-1:0]               paddr_q, paddr_d;
  logic                        hit1_q, hit1_d, hit2_q, hit2_d;
  logic [AW-1:0]               idx1_q, idx1_d;
  lob_pkg::ord_t               d1_q, d1_d;

  logic [lob_pkg::STATUS_W-1:0] st_q, st_d;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [lob_pkg::STATUS_W-1:0]  o_status_q;
  logic                          o_lvalid_q;
  logic [lob_pkg::PRICE_W-1:0]   o_lprice_q, o_bid_q, o_ask_q;
  logic [lob_pkg::LSH_W-1:0]     o_lshares_q;
  logic [lob_pkg::LORD_W-1:0]    o_lorders_q;
  logic                          o_load;

  // RAM ports.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  lob_pkg::ord_t wdata, rd;
  logic [OW-1:0] rdata;
  logic [CW-1:0] cnt_m1;

  // Level rows.
  lob_pkg::lvl_op_t   op_c, bid_op, ask_op;
  logic               op_side, clr;
  lob_pkg::lvl_stat_t bid_st, ask_st;
  logic               add_ok;
  lob_pkg::lvl_entry_t rd_lvl;

  logic accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign cnt_m1 = cnt_q - CW'(1);
  assign raddr  = (state_q == S_SCAN) ? iss_q[AW-1:0] : cnt_m1[AW-1:0];
  assign rd     = lob_pkg::ord_t'(rdata);

  lob_ram #(.WIDTH(OW), .DEPTH(MAX_ORDERS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Route the level operation to the side it concerns; clear hits both.
  always_comb begin
    bid_op      = op_c;
    ask_op      = op_c;
    bid_op.code = clr ? lob_pkg::LOP_CLR : (op_side ? lob_pkg::LOP_NOP : op_c.code);
    ask_op.code = clr ? lob_pkg::LOP_CLR : (op_side ? op_c.code : lob_pkg::LOP_NOP);
    add_ok      = op_side ? ask_st.add_ok : bid_st.add_ok;
    rd_lvl      = side_q ? ask_st.rd : bid_st.rd;
  end

  lob_level_side #(.IS_ASK(1'b0), .MAX_LEVELS(MAX_LEVELS)) u_bid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (bid_op),
    .rank_i (rank_q),
    .stat_o (bid_st)
  );

  lob_level_side #(.IS_ASK(1'b1), .MAX_LEVELS(MAX_LEVELS)) u_ask (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (ask_op),
    .rank_i (rank_q),
    .stat_o (ask_st)
  );

  // Message sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lock_d  = lock_q;
    symv_d  = symv_q;
    iss_d   = iss_q;
    pend_d  = pend_q;
    paddr_d = paddr_q;
    hit1_d  = hit1_q;
    hit2_d  = hit2_q;
    idx1_d  = idx1_q;
    d1_d    = d1_q;
    st_d    = st_q;
    we      = 1'b0;
    waddr   = idx1_q;
    wdata   = rd;
    clr     = 1'b0;
    op_side = side_q;
    op_c    = '{code: lob_pkg::LOP_NOP, price: price_q, amount: shares_q, dec: 1'b0};
    o_load  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        st_d    = lob_pkg::ST_OK;
        iss_d   = '0;
        pend_d  = 1'b0;
        hit1_d  = 1'b0;
        hit2_d  = 1'b0;
        state_d = S_RESP;
        if (cmd_q == lob_pkg::CMD_ADD || cmd_q == lob_pkg::CMD_REDUCE ||
            cmd_q == lob_pkg::CMD_DELETE || cmd_q == lob_pkg::CMD_REPLACE) begin
          state_d = S_SCAN;
        end else if (cmd_q == lob_pkg::CMD_CLEAR) begin
          clr    = 1'b1;
          cnt_d  = '0;
          lock_d = 1'b0;
          symv_d = '0;
        end
      end
      S_SCAN: begin
        // One read issued per cycle; its data is compared in the cycle after.
        if (iss_q < cnt_q) begin
          iss_d   = iss_q + CW'(1);
          pend_d  = 1'b1;
          paddr_d = iss_q[AW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (rd.key == id_q) begin
            hit1_d = 1'b1;
            idx1_d = paddr_q;
            d1_d   = rd;
          end
          if (rd.key == nid_q) begin
            hit2_d = 1'b1;
          end
        end
        if (iss_q >= cnt_q && !pend_q) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        case (cmd_q)
          lob_pkg::CMD_ADD: begin
            if (shares_q == '0 || sym_q == '0) begin
              st_d = lob_pkg::ST_BAD_ADD;
            end else if (lock_q && symv_q != sym_q) begin
              st_d = lob_pkg::ST_SYMBOL;
            end else if (hit1_q) begin
              st_d = lob_pkg::ST_DUP;
            end else if (cnt_q == CW'(MAX_ORDERS) || !add_ok) begin
              st_d = lob_pkg::ST_FULL;
            end else begin
              op_c.code = lob_pkg::LOP_ADD;
              we        = 1'b1;
              waddr     = cnt_q[AW-1:0];
              wdata     = '{key: id_q, side: side_q, price: price_q, rem: shares_q};
              cnt_d     = cnt_q + CW'(1);
              lock_d    = 1'b1;
              symv_d    = sym_q;
            end
          end
          lob_pkg::CMD_REDUCE: begin
            op_side    = d1_q.side;
            op_c.price = d1_q.price;
            if (!hit1_q) begin
              st_d = lob_pkg::ST_UNKNOWN;
            end else if (shares_q == '0 || shares_q > d1_q.rem) begin
              st_d = lob_pkg::ST_BAD_RED;
            end else begin
              op_c.code = lob_pkg::LOP_SUB;
              op_c.dec  = (shares_q == d1_q.rem);
              if (shares_q == d1_q.rem) begin
                state_d = S_MOVE;
              end else begin
                we        = 1'b1;
                wdata     = d1_q;
                wdata.rem = d1_q.rem - shares_q;
              end
            end
          end
          lob_pkg::CMD_DELETE, lob_pkg::CMD_REPLACE: begin
            op_side     = d1_q.side;
            op_c.price  = d1_q.price;
            op_c.amount = d1_q.rem;
            op_c.dec    = 1'b1;
            if (!hit1_q) begin
              st_d = lob_pkg::ST_UNKNOWN;
            end else if (cmd_q == lob_pkg::CMD_REPLACE && (shares_q == '0 || hit2_q)) begin
              st_d = lob_pkg::ST_BAD_REPL;
            end else begin
              op_c.code = lob_pkg::LOP_SUB;
              state_d   = S_MOVE;
            end
          end
          default: begin
          end
        endcase
      end
      S_MOVE: begin
        // Close the hole by moving the last live order into it.
        we      = 1'b1;
        wdata   = rd;
        cnt_d   = cnt_m1;
        state_d = (cmd_q == lob_pkg::CMD_REPLACE) ? S_REPL : S_RESP;
      end
      S_REPL: begin
        op_side = d1_q.side;
        waddr   = cnt_q[AW-1:0];
        if (add_ok) begin
          op_c.code = lob_pkg::LOP_ADD;
          we        = 1'b1;
          wdata     = '{key: nid_q, side: d1_q.side, price: price_q, rem: shares_q};
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_RESP;
        end else begin
          st_d    = lob_pkg::ST_FULL;
          state_d = S_UNDO;
        end
      end
      S_UNDO: begin
        // Put the original order back unchanged, at the end of the packed store.
        op_side     = d1_q.side;
        op_c.code   = lob_pkg::LOP_ADD;
        op_c.price  = d1_q.price;
        op_c.amount = d1_q.rem;
        we          = 1'b1;
        waddr       = cnt_q[AW-1:0];
        wdata       = d1_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          o_load      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lock_q      <= 1'b0;
      symv_q      <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      hit1_q      <= 1'b0;
      hit2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lock_q      <= lock_d;
      symv_q      <= symv_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      hit1_q      <= hit1_d;
      hit2_q      <= hit2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Message capture, scan payload and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      id_q     <= order_id_i;
      nid_q    <= new_order_id_i;
      side_q   <= side_i;
      price_q  <= price_i;
      shares_q <= shares_i;
      sym_q    <= symbol_code_i;
      rank_q   <= level_rank_i;
    end
    paddr_q <= paddr_d;
    idx1_q  <= idx1_d;
    d1_q    <= d1_d;
    st_q    <= st_d;
    if (o_load) begin
      o_status_q <= st_q;
      o_bid_q    <= bid_st.best_price;
      o_ask_q    <= ask_st.best_price;
      if (cmd_q == lob_pkg::CMD_READ) begin
        o_lvalid_q  <= rd_lvl.valid;
        o_lprice_q  <= rd_lvl.price;
        o_lshares_q <= rd_lvl.shares;
        o_lorders_q <= rd_lvl.orders;
      end else begin
        o_lvalid_q  <= 1'b0;
        o_lprice_q  <= '0;
        o_lshares_q <= '0;
        o_lorders_q <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign level_valid_o    = o_lvalid_q;
  assign level_price_o    = o_lprice_q;
  assign level_shares_o   = o_lshares_q;
  assign level_orders_o   = o_lorders_q;
  assign best_bid_price_o = o_bid_q;
  assign best_ask_price_o = o_ask_q;

endmodule

[tb/tb_limit_order_book_unit.sv]
// Self-checking testbench for limit_order_book_unit: directed table, book-filling phase, random traffic.
// Depends on lob_pkg and the RTL under rtl/core; the book predictor is kept locally.
`timescale 1ns / 1ps

module tb_limit_order_book_unit;
  import lob_pkg::*;

  localparam int ORD_CAP = 1024;
  localparam int LVL_CAP = 64;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [SYM_W-1:0] SYM_MAIN  = 64'h4142_4344_2020_2020;
  localparam logic [SYM_W-1:0] SYM_OTHER = 64'h5859_5A20_2020_2020;
  localparam int IDLE_LIMIT = 40000;
  localparam int TAIL_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 790;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     id;
    logic [ID_W-1:0]     nid;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [SHARES_W-1:0] shares;
    logic [SYM_W-1:0]    sym;
    logic [RANK_W-1:0]   rank;
  } msg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                lvalid;
    logic [PRICE_W-1:0]  lprice;
    logic [LSH_W-1:0]    lshares;
    logic [LORD_W-1:0]   lorders;
    logic [PRICE_W-1:0]  buy_top;
    logic [PRICE_W-1:0]  sell_top;
  } res_t;

  typedef struct packed {
    logic side;
    logic [PRICE_W-1:0] price;
    logic [SHARES_W-1:0] rem;
  } rest_t;

  typedef struct {
    msg_t msg;
    bit   typed;
    res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  msg_t drv_msg = '0;
  bit   drv_typed = 1'b0;
  res_t drv_res = '0;
  logic [STATUS_W-1:0] status_o;
  logic                level_valid_o;
  logic [PRICE_W-1:0]  level_price_o;
  logic [LSH_W-1:0]    level_shares_o;
  logic [LORD_W-1:0]   level_orders_o;
  logic [PRICE_W-1:0]  best_bid_price_o;
  logic [PRICE_W-1:0]  best_ask_price_o;

  // Predicted book state.
  rest_t              resting[logic [ID_W-1:0]];
  logic [PRICE_W-1:0] lvl_price[2][LVL_CAP];
  logic [LSH_W-1:0]   lvl_shares[2][LVL_CAP];
  int                 lvl_orders[2][LVL_CAP];
  int                 lvl_count[2];
  bit                 sym_locked;
  logic [SYM_W-1:0]   sym_value;

  res_t pending_results[$];
  row_t rows[$];
  int   errors = 0;
  int   mismatches = 0;
  int   sent = 0;
  int   received = 0;
  int   idle_cycles = 0;
  int   status_seen[8];
  bit   no_gaps = 1'b0;

  limit_order_book_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (drv_msg.cmd),
    .order_id_i       (drv_msg.id),
    .new_order_id_i   (drv_msg.nid),
    .side_i           (drv_msg.side),
    .price_i          (drv_msg.price),
    .shares_i         (drv_msg.shares),
    .symbol_code_i    (drv_msg.sym),
    .level_rank_i     (drv_msg.rank),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .level_valid_o    (level_valid_o),
    .level_price_o    (level_price_o),
    .level_shares_o   (level_shares_o),
    .level_orders_o   (level_orders_o),
    .best_bid_price_o (best_bid_price_o),
    .best_ask_price_o (best_ask_price_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Empty the whole book.
  function automatic void book_clear();
    resting.delete();
    lvl_count[0] = 0;
    lvl_count[1] = 0;
    sym_locked = 1'b0;
    sym_value = '0;
  endfunction

  // Rank where a price belongs on a side; found is set when the level exists.
  function automatic int level_slot(logic s, logic [PRICE_W-1:0] p, output bit found);
    found = 1'b0;
    for (int i = 0; i < lvl_count[s]; i++) begin
      if (s == 1'b0 ? lvl_price[s][i] <= p : lvl_price[s][i] >= p) begin
        found = (lvl_price[s][i] == p);
        return i;
      end
    end
    return lvl_count[s];
  endfunction

  function automatic logic [STATUS_W-1:0] book_add(logic [ID_W-1:0] id, logic s,
      logic [PRICE_W-1:0] p, logic [SHARES_W-1:0] sh, logic [SYM_W-1:0] sym);
    int  pos;
    bit  found;
    if (sh == 0 || sym == 0) return ST_BAD_ADD;
    if (sym_locked && sym_value != sym) return ST_SYMBOL;
    if (resting.exists(id)) return ST_DUP;
    if (resting.num() >= ORD_CAP) return ST_FULL;
    pos = level_slot(s, p, found);
    if (found) begin
      if ({1'b0, lvl_shares[s][pos]} + (LSH_W+1)'(sh) > {1'b0, {LSH_W{1'b1}}}) return ST_FULL;
      if (lvl_orders[s][pos] >= 2047) return ST_FULL;
      lvl_shares[s][pos] += LSH_W'(sh);
      lvl_orders[s][pos] += 1;
    end else begin
      if (lvl_count[s] >= LVL_CAP) return ST_FULL;
      for (int k = lvl_count[s]; k > pos; k--) begin
        lvl_price[s][k] = lvl_price[s][k-1];
        lvl_shares[s][k] = lvl_shares[s][k-1];
        lvl_orders[s][k] = lvl_orders[s][k-1];
      end
      lvl_price[s][pos] = p;
      lvl_shares[s][pos] = LSH_W'(sh);
      lvl_orders[s][pos] = 1;
      lvl_count[s] += 1;
    end
    resting[id] = '{side: s, price: p, rem: sh};
    sym_locked = 1'b1;
    sym_value = sym;
    return ST_OK;
  endfunction

  // Take shares off a resting order; a whole removal takes all that remain.
  function automatic logic [STATUS_W-1:0] book_reduce(logic [ID_W-1:0] id,
      logic [SHARES_W-1:0] amt, bit whole);
    rest_t o;
    int    pos;
    bit    found;
    if (!resting.exists(id)) return ST_UNKNOWN;
    o = resting[id];
    if (!whole && (amt == 0 || amt > o.rem)) return ST_BAD_RED;
    if (whole) amt = o.rem;
    pos = level_slot(o.side, o.price, found);
    o.rem -= amt;
    resting[id] = o;
    if (found) begin
      lvl_shares[o.side][pos] = lvl_shares[o.side][pos] >= LSH_W'(amt) ?
                                lvl_shares[o.side][pos] - LSH_W'(amt) : '0;
    end
    if (o.rem == 0) begin
      resting.delete(id);
      if (found && lvl_orders[o.side][pos] > 0) lvl_orders[o.side][pos] -= 1;
    end
    if (found && lvl_orders[o.side][pos] == 0) begin
      for (int k = pos; k + 1 < lvl_count[o.side]; k++) begin
        lvl_price[o.side][k] = lvl_price[o.side][k+1];
        lvl_shares[o.side][k] = lvl_shares[o.side][k+1];
        lvl_orders[o.side][k] = lvl_orders[o.side][k+1];
      end
      lvl_count[o.side] -= 1;
    end
    return ST_OK;
  endfunction

  // Apply one message to the predicted book and return the expected result.
  function automatic res_t book_step(msg_t m);
    res_t               r;
    rest_t              keep_rest[logic [ID_W-1:0]];
    logic [PRICE_W-1:0] keep_price[2][LVL_CAP];
    logic [LSH_W-1:0]   keep_shares[2][LVL_CAP];
    int                 keep_orders[2][LVL_CAP];
    int                 keep_count[2];
    logic               s;
    r = '0;
    case (m.cmd)
      CMD_ADD:    r.status = book_add(m.id, m.side, m.price, m.shares, m.sym);
      CMD_REDUCE: r.status = book_reduce(m.id, m.shares, 1'b0);
      CMD_DELETE: r.status = book_reduce(m.id, '0, 1'b1);
      CMD_REPLACE: begin
        if (!resting.exists(m.id)) begin
          r.status = ST_UNKNOWN;
        end else if (m.shares == 0 || resting.exists(m.nid)) begin
          r.status = ST_BAD_REPL;
        end else begin
          keep_rest = resting;
          keep_price = lvl_price;
          keep_shares = lvl_shares;
          keep_orders = lvl_orders;
          keep_count = lvl_count;
          s = resting[m.id].side;
          void'(book_reduce(m.id, '0, 1'b1));
          r.status = book_add(m.nid, s, m.price, m.shares, sym_value);
          // A failed replace leaves the book as it was.
          if (r.status != ST_OK) begin
            resting = keep_rest;
            lvl_price = keep_price;
            lvl_shares = keep_shares;
            lvl_orders = keep_orders;
            lvl_count = keep_count;
          end
        end
      end
      CMD_READ: begin
        if (m.rank < lvl_count[m.side]) begin
          r.lvalid = 1'b1;
          r.lprice = lvl_price[m.side][m.rank];
          r.lshares = lvl_shares[m.side][m.rank];
          r.lorders = LORD_W'(lvl_orders[m.side][m.rank]);
        end
      end
      CMD_CLEAR: book_clear();
      default: ;
    endcase
    r.buy_top = lvl_count[0] > 0 ? lvl_price[0][0] : '0;
    r.sell_top = lvl_count[1] > 0 ? lvl_price[1][0] : '0;
    return r;
  endfunction

  function automatic msg_t mk(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
      logic [ID_W-1:0] nid, logic s, logic [PRICE_W-1:0] p,
      logic [SHARES_W-1:0] sh, logic [SYM_W-1:0] sym, logic [RANK_W-1:0] rk);
    msg_t m;
    m = '{cmd: c, id: id, nid: nid, side: s, price: p, shares: sh, sym: sym, rank: rk};
    return m;
  endfunction

  function automatic void add_row(msg_t m, bit typed = 1'b0, res_t r = '0);
    row_t rw;
    rw = '{msg: m, typed: typed, res: r};
    rows.insert(rows.size(), rw);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one message and hold it until the transfer happens.
  task automatic send(msg_t m, bit typed = 1'b0, res_t r = '0);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv_msg <= m;
    drv_typed <= typed;
    drv_res <= r;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    if ($urandom_range(0, 99) < 88) return ID_W'($urandom_range(0, 47));
    return {$urandom, $urandom};
  endfunction

  function automatic msg_t rand_msg();
    msg_t m;
    int   pick;
    int   cp;
    m.id = rand_id();
    m.nid = rand_id();
    m.side = 1'($urandom_range(0, 1));
    m.rank = $urandom_range(0, 99) < 70 ? RANK_W'($urandom_range(0, 7)) :
             RANK_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    m.price = pick < 85 ? 32'd1000 + $urandom_range(0, 24) :
              pick < 92 ? $urandom : (pick < 96 ? 32'd0 : 32'hFFFF_FFFF);
    pick = $urandom_range(0, 99);
    m.shares = pick < 80 ? $urandom_range(1, 500) :
               pick < 88 ? 32'd0 : (pick < 94 ? 32'hFFFF_FFFF : $urandom);
    pick = $urandom_range(0, 99);
    m.sym = pick < 90 ? SYM_MAIN : pick < 94 ? '0 : pick < 97 ? SYM_OTHER : {$urandom, $urandom};
    cp = $urandom_range(0, 99);
    m.cmd = cp < 36 ? CMD_ADD : cp < 56 ? CMD_REDUCE : cp < 68 ? CMD_DELETE :
            cp < 83 ? CMD_REPLACE : cp < 96 ? CMD_READ : cp < 98 ? CMD_CLEAR :
            (cp < 99 ? CMD_SPARE6 : CMD_SPARE7);
    return m;
  endfunction

  // Every transfer into the block updates the predicted book.
  always @(posedge clk_i) begin
    res_t r;
    if (in_valid_i && !in_stall_o) begin
      r = book_step(drv_msg);
      pending_results.insert(pending_results.size(), drv_typed ? drv_res : r);
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (out_valid_o && !out_stall_i) begin
      got = '{status_o, level_valid_o, level_price_o, level_shares_o, level_orders_o,
              best_bid_price_o, best_ask_price_o};
      received++;
      status_seen[status_o]++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10) begin
            $display("ERROR: result %0d mismatch", received);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // Receiver stalls: random runs, mostly short.
  always @(posedge clk_i) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps) out_stall_i <= 1'b0;
    else if (pick < 4) out_stall_i <= 1'b1;
    else if (out_stall_i && pick < 70) out_stall_i <= 1'b1;
    else out_stall_i <= pick < 25;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    res_t empty;
    msg_t m;
    int   n;
    empty = '0;
    book_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset state, field extremes, each command and each error but ST_FULL.
    add_row(mk(CMD_READ, 0, 0, 0, 0, 0, SYM_MAIN, 0), 1'b1, empty);
    add_row(mk(CMD_READ, 0, 0, 1, 0, 0, SYM_MAIN, 63), 1'b1, empty);
    add_row(mk(CMD_ADD, 5, 0, 0, 100, 0, SYM_MAIN, 0), 1'b1, '{ST_BAD_ADD, 0, 0, 0, 0, 0, 0});
    add_row(mk(CMD_ADD, 5, 0, 0, 100, 10, 0, 0), 1'b1, '{ST_BAD_ADD, 0, 0, 0, 0, 0, 0});
    add_row(mk(CMD_REDUCE, 5, 0, 0, 0, 1, SYM_MAIN, 0), 1'b1, '{ST_UNKNOWN, 0, 0, 0, 0, 0, 0});
    add_row(mk(CMD_ADD, 0, 0, 0, 100, 10, SYM_MAIN, 0));
    add_row(mk(CMD_ADD, '1, 0, 1, '1, '1, SYM_MAIN, 0));
    add_row(mk(CMD_ADD, 7, 0, 0, 0, 3, SYM_MAIN, 0));
    add_row(mk(CMD_ADD, 8, 0, 1, 200, 3, '1, 0));
    add_row(mk(CMD_ADD, 0, 0, 1, 300, 3, SYM_MAIN, 0));
    add_row(mk(CMD_REDUCE, 0, 0, 0, 0, 0, SYM_MAIN, 0));
    add_row(mk(CMD_REDUCE, 0, 0, 0, 0, 11, SYM_MAIN, 0));
    add_row(mk(CMD_REDUCE, 0, 0, 0, 0, 4, SYM_MAIN, 0));
    add_row(mk(CMD_READ, 0, 0, 0, 0, 0, SYM_MAIN, 0));
    add_row(mk(CMD_REDUCE, 0, 0, 0, 0, 6, SYM_MAIN, 0));
    add_row(mk(CMD_DELETE, 99, 0, 0, 0, 0, SYM_MAIN, 0));
    add_row(mk(CMD_REPLACE, 99, 3, 0, 50, 5, SYM_MAIN, 0));
    add_row(mk(CMD_REPLACE, 7, 3, 0, 50, 0, SYM_MAIN, 0));
    add_row(mk(CMD_REPLACE, 7, 7, 0, 50, 5, SYM_MAIN, 0));
    add_row(mk(CMD_REPLACE, 7, '1, 0, 50, 5, SYM_MAIN, 0));
    add_row(mk(CMD_REPLACE, 7, 3, 0, 50, 5, SYM_MAIN, 0));
    add_row(mk(CMD_READ, 0, 0, 1, 0, 0, SYM_MAIN, 0));
    add_row(mk(CMD_SPARE6, '1, '1, 1, '1, '1, '1, '1));
    add_row(mk(CMD_SPARE7, 3, 0, 0, 0, 0, 0, 0));
    add_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b1, empty);
    foreach (rows[i]) send(rows[i].msg, rows[i].typed, rows[i].res);

    // Hold off until the book has answered everything.
    drain();

    // Fill phase: level share overflow, a full level row and a full order table.
    no_gaps = 1'b1;
    for (int i = 0; i < 257; i++)
      send(mk(CMD_ADD, ID_W'(1000 + i), 0, 0, 5000, '1, SYM_MAIN, 0));
    for (int i = 0; i < 768; i++)
      send(mk(CMD_ADD, ID_W'(2000 + i), 0, 0, PRICE_W'(4000 + i % 63), SHARES_W'(i + 1),
              SYM_MAIN, 0));
    send(mk(CMD_ADD, 9000, 0, 0, 10, 1, SYM_MAIN, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, SYM_MAIN, 63));
    send(mk(CMD_DELETE, 2000, 0, 0, 0, 0, SYM_MAIN, 0));
    send(mk(CMD_ADD, 9000, 0, 0, 10, 1, SYM_MAIN, 0));
    send(mk(CMD_REPLACE, 2001, 9001, 0, 11, 5, SYM_MAIN, 0));
    send(mk(CMD_REPLACE, 2001, 9001, 0, 4005, 5, SYM_MAIN, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, SYM_MAIN, 0));
    send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    no_gaps = 1'b0;

    // Random traffic: well-formed book activity with some malformed messages.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      m = rand_msg();
      send(m);
      n++;
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d messages, %0d results; status counts ok %0d full %0d.",
             sent, received, status_seen[ST_OK], status_seen[ST_FULL]);
    $display("Mismatches: %0d, expectations left: %0d.", mismatches, pending_results.size());
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[limit_order_book_unit.f]
rtl/core/lob_pkg.sv
rtl/core/lob_ram.sv
rtl/core/lob_level_cell.sv
rtl/core/lob_level_side.sv
rtl/core/limit_order_book_unit.sv
tb/tb_limit_order_book_unit.sv
